// ===== hdl/bal_pkg.sv =====
package bal_pkg;

  // default geometry
  localparam int DEPTH_DEF = 16;
  localparam int WIDTH_DEF = 32;

  // match bits looked at per scan step
  localparam int SCAN_GROUP = 8;

  // request codes
  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_FIND       = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  // shift command broadcast to the cell row
  typedef enum logic [1:0] {
    SH_NONE  = 2'd0,
    SH_OPEN  = 2'd1,
    SH_CLOSE = 2'd2
  } shift_t;

  // control state of the top level
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // top level to finder
  typedef struct packed {
    logic start;
    logic step;
  } find_ctl_t;

  // finder to top level
  typedef struct packed {
    logic done;
    logic hit;
  } find_res_t;

endpackage

// ===== hdl/bal_cell.sv =====
module bal_cell #(
  parameter int DEPTH = bal_pkg::DEPTH_DEF,
  parameter int WIDTH = bal_pkg::WIDTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                 clk,
  input  bal_pkg::shift_t      kind,
  input  logic [$clog2(DEPTH)-1:0] at,
  input  logic [WIDTH-1:0]     value,
  input  logic [WIDTH-1:0]     prev_word,
  input  logic [WIDTH-1:0]     next_word,
  output logic [WIDTH-1:0]     word,
  output logic                 match
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  logic [WIDTH-1:0] word_next;

  // open: cells above the gap take from below, the gap cell takes the value
  // close: cells at and above the gap take from above
  always_comb begin
    word_next = word;
    case (kind)
      bal_pkg::SH_OPEN: begin
        if (MY_IDX > at) begin
          word_next = prev_word;
        end else if (MY_IDX == at) begin
          word_next = value;
        end
      end
      bal_pkg::SH_CLOSE: begin
        if (MY_IDX >= at) begin
          word_next = next_word;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // local compare for find
  assign match = (word == value);

endmodule

// ===== hdl/bal_finder.sv =====
module bal_finder #(
  parameter int DEPTH = bal_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bal_pkg::find_ctl_t         ctl,
  input  logic [DEPTH-1:0]           hits_in,
  output bal_pkg::find_res_t         res,
  output logic [$clog2(DEPTH+1)-1:0] pos
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int GS = bal_pkg::SCAN_GROUP;
  localparam int NG = (DEPTH + GS - 1) / GS;
  localparam int GW = $clog2(NG + 1);
  localparam int HW = NG * GS;
  localparam int SW = $clog2(GS);

  logic [HW-1:0] hits;
  logic [GW-1:0] grp;
  logic          any;
  logic [SW-1:0] first;

  // hit vector shifts down one group per step
  always_ff @(posedge clk) begin
    if (rst) begin
      grp <= '0;
    end else if (ctl.start) begin
      grp <= '0;
    end else if (ctl.step) begin
      grp <= grp + GW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      hits <= HW'(hits_in);
    end else if (ctl.step) begin
      hits <= hits >> GS;
    end
  end

  // first set bit of the low group
  always_comb begin
    any   = 1'b0;
    first = '0;
    for (int i = GS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        any   = 1'b1;
        first = SW'(i);
      end
    end
  end

  assign res.hit  = any;
  assign res.done = any || (grp == GW'(NG - 1));
  assign pos      = (CW'(grp) << SW) + CW'(first) + CW'(1);

endmodule

// ===== hdl/bounded_array_list_engine.sv =====
// Bounded ordered list of up to DEPTH signed WIDTH-bit words held in a row of
// register cells, one word per cell; push, pop front, insert and erase shift
// the cells from the target position upward by one place, pop back only
// lowers the count and clear only resets it. Every request gives one result
// with a status, a one-based found position and the element count after the
// request. All requests other than find are taken one per cycle while the
// result side is not stalled, and their result is registered in the cycle
// after acceptance. Find compares every cell in the accepting cycle, then
// scans the match bits eight per cycle while the result side is free, so it
// holds the input off until the scan ends and its result is registered. Refused
// requests (push on a full list, pop on an empty list, out-of-range position) leave the list untouched.
module bounded_array_list_engine #(
  parameter int DEPTH = bal_pkg::DEPTH_DEF,
  parameter int WIDTH = bal_pkg::WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 op,
  input  logic [$clog2(DEPTH+1)-1:0] position,
  input  logic signed [WIDTH-1:0]    value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [$clog2(DEPTH+1)-1:0] found_position,
  output logic [$clog2(DEPTH+1)-1:0] element_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bal_pkg::state_t    state, state_next;
  bal_pkg::op_t       req;
  bal_pkg::shift_t    kind;
  bal_pkg::status_t   stat_now;
  bal_pkg::find_ctl_t fctl;
  bal_pkg::find_res_t fres;

  logic [CW-1:0]    count, count_next;
  logic [AW-1:0]    at;
  logic [CW-1:0]    fpos;
  logic             acc;
  logic             out_free;
  logic             full;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] hits;
  logic [WIDTH-1:0] words [DEPTH];

  assign req      = bal_pkg::op_t'(op);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign full     = (count == CW'(DEPTH));

  // request decode: shift command, status and new count
  always_comb begin
    kind       = bal_pkg::SH_NONE;
    at         = '0;
    stat_now   = bal_pkg::STAT_OK;
    count_next = count;
    case (req)
      bal_pkg::OP_PUSH_BACK: begin
        if (full) begin
          stat_now = bal_pkg::STAT_FULL;
        end else begin
          kind       = bal_pkg::SH_OPEN;
          at         = count[AW-1:0];
          count_next = count + CW'(1);
        end
      end
      bal_pkg::OP_POP_BACK: begin
        if (count == '0) begin
          stat_now = bal_pkg::STAT_RANGE;
        end else begin
          count_next = count - CW'(1);
        end
      end
      bal_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          stat_now = bal_pkg::STAT_FULL;
        end else begin
          kind       = bal_pkg::SH_OPEN;
          count_next = count + CW'(1);
        end
      end
      bal_pkg::OP_POP_FRONT: begin
        if (count == '0) begin
          stat_now = bal_pkg::STAT_RANGE;
        end else begin
          kind       = bal_pkg::SH_CLOSE;
          count_next = count - CW'(1);
        end
      end
      bal_pkg::OP_INSERT: begin
        if (position > count) begin
          stat_now = bal_pkg::STAT_RANGE;
        end else if (full) begin
          stat_now = bal_pkg::STAT_FULL;
        end else begin
          kind       = bal_pkg::SH_OPEN;
          at         = position[AW-1:0];
          count_next = count + CW'(1);
        end
      end
      bal_pkg::OP_ERASE: begin
        if (position >= count) begin
          stat_now = bal_pkg::STAT_RANGE;
        end else begin
          kind       = bal_pkg::SH_CLOSE;
          at         = position[AW-1:0];
          count_next = count - CW'(1);
        end
      end
      bal_pkg::OP_FIND: begin
        stat_now = bal_pkg::STAT_MISSING;
      end
      bal_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // row of cells, each wired to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = words[i+1];
    end

    bal_cell #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .kind      (acc ? kind : bal_pkg::SH_NONE),
      .at        (at),
      .value     (value),
      .prev_word (prev_w),
      .next_word (next_w),
      .word      (words[i]),
      .match     (match[i])
    );

    // only cells below the count take part in find
    assign hits[i] = match[i] && (CW'(i) < count);
  end

  bal_finder #(
    .DEPTH (DEPTH)
  ) u_finder (
    .clk     (clk),
    .rst     (rst),
    .ctl     (fctl),
    .hits_in (hits),
    .res     (fres),
    .pos     (fpos)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bal_pkg::ST_IDLE: begin
        if (acc && req == bal_pkg::OP_FIND) begin
          state_next = bal_pkg::ST_SCAN;
        end
      end
      bal_pkg::ST_SCAN: begin
        if (out_free && fres.done) begin
          state_next = bal_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bal_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_stall   = 1'b1;
    fctl.start = 1'b0;
    fctl.step  = 1'b0;
    case (state)
      bal_pkg::ST_IDLE: begin
        in_stall   = out_valid && out_stall;
        fctl.start = in_valid && !in_stall && (req == bal_pkg::OP_FIND);
      end
      bal_pkg::ST_SCAN: begin
        fctl.step = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bal_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (acc) begin
        count <= count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc && req != bal_pkg::OP_FIND) begin
      out_valid <= 1'b1;
    end else if (state == bal_pkg::ST_SCAN && out_free && fres.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && req != bal_pkg::OP_FIND) begin
      status         <= stat_now;
      found_position <= '0;
      element_count  <= count_next;
    end else if (state == bal_pkg::ST_SCAN && out_free && fres.done) begin
      status         <= fres.hit ? bal_pkg::STAT_OK : bal_pkg::STAT_MISSING;
      found_position <= fres.hit ? fpos : '0;
      element_count  <= count;
    end
  end

  // count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count beyond capacity");

  // no item taken while a find is being scanned
  a_scan_stall: assert property (@(posedge clk) disable iff (rst)
    state == bal_pkg::ST_SCAN |-> in_stall)
    else $error("input accepted during find scan");

  // a position is reported only with a successful find
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bal_pkg::STAT_OK |-> found_position == '0)
    else $error("found position without success");

  // clear gives an empty list in the next result
  a_clear: assert property (@(posedge clk) disable iff (rst)
    acc && req == bal_pkg::OP_CLEAR |=> out_valid && element_count == '0)
    else $error("clear did not empty the list");

endmodule

// ===== bench/bounded_array_list_engine_tb.sv =====
`timescale 1ns / 1ps

module bounded_array_list_engine_tb;

  localparam int LIST_DEPTH   = bal_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 48;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    bal_pkg::status_t status;
    logic [4:0]       found;
    logic [4:0]       count;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  op;
  logic [4:0]  position;
  logic [31:0] value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [4:0]  found_position;
  logic [4:0]  element_count;

  // shadow copy of the list, advanced on every accepted item
  logic [31:0] list_words [LIST_DEPTH];
  int          list_len;
  reply_t      pending [$];

  int errors;
  int accepted;
  int checked;
  int finds_hit;
  int refused;
  int full_seen;
  int empty_seen;
  int cycle_count;
  bit quiet;
  int hold_reqs;
  int hold_done;
  int hold_left;
  int stall_left;

  bounded_array_list_engine i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .position       (position),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_position (found_position),
    .element_count  (element_count)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // open a slot at index at and store w there
  function automatic void place_word(int at, logic [31:0] w);
    for (int i = list_len; i > at; i--) begin
      list_words[i] = list_words[i-1];
    end
    list_words[at] = w;
    list_len++;
  endfunction

  // remove the word at index at and close the slot
  function automatic void drop_word(int at);
    for (int i = at; i + 1 < list_len; i++) begin
      list_words[i] = list_words[i+1];
    end
    list_len--;
  endfunction

  // apply one request to the shadow list and return the reply it should give
  function automatic reply_t apply_request(bal_pkg::op_t o, logic [4:0] p,
                                           logic [31:0] v);
    reply_t r;
    r.status = bal_pkg::STAT_OK;
    r.found  = '0;
    case (o)
      bal_pkg::OP_PUSH_BACK: begin
        if (list_len >= LIST_DEPTH) r.status = bal_pkg::STAT_FULL;
        else place_word(list_len, v);
      end
      bal_pkg::OP_POP_BACK: begin
        if (list_len == 0) r.status = bal_pkg::STAT_RANGE;
        else list_len--;
      end
      bal_pkg::OP_PUSH_FRONT: begin
        if (list_len >= LIST_DEPTH) r.status = bal_pkg::STAT_FULL;
        else place_word(0, v);
      end
      bal_pkg::OP_POP_FRONT: begin
        if (list_len == 0) r.status = bal_pkg::STAT_RANGE;
        else drop_word(0);
      end
      bal_pkg::OP_INSERT: begin
        // range check wins over the full check
        if (int'(p) > list_len) r.status = bal_pkg::STAT_RANGE;
        else if (list_len >= LIST_DEPTH) r.status = bal_pkg::STAT_FULL;
        else place_word(int'(p), v);
      end
      bal_pkg::OP_ERASE: begin
        if (int'(p) >= list_len) r.status = bal_pkg::STAT_RANGE;
        else drop_word(int'(p));
      end
      bal_pkg::OP_FIND: begin
        r.status = bal_pkg::STAT_MISSING;
        for (int i = 0; i < list_len; i++) begin
          if (r.status == bal_pkg::STAT_MISSING && list_words[i] == v) begin
            r.status = bal_pkg::STAT_OK;
            r.found  = 5'(i + 1);
          end
        end
      end
      default: begin
        list_len = 0;
      end
    endcase
    r.count = 5'(list_len);
    return r;
  endfunction

  // check results against the oldest expectation, then predict new items
  always @(posedge clk) begin : scoreboard
    reply_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          $error("result with no request pending: status %0d count %0d",
                 status, element_count);
          errors++;
        end else begin
          want = pending.pop_front();
          checked++;
          if (want.found != 0) finds_hit++;
          if (want.status != bal_pkg::STAT_OK && want.status != bal_pkg::STAT_MISSING)
            refused++;
          if (want.count == LIST_DEPTH) full_seen++;
          if (want.count == 0) empty_seen++;
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          if (found_position !== want.found) begin
            $error("found_position: expected %0d, got %0d", want.found, found_position);
            errors++;
          end
          if (element_count !== want.count) begin
            $error("element_count: expected %0d, got %0d", want.count, element_count);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending.push_back(apply_request(bal_pkg::op_t'(op), position, value));
        accepted++;
      end
    end
  end

  // result side pacing, with an occasional long hold-off on request
  always @(negedge clk) begin : result_pacing
    int r;
    if (hold_done != hold_reqs) begin
      hold_done = hold_reqs;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (quiet || rst) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        out_stall <= 1'b0;
      end else begin
        out_stall  <= 1'b1;
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 30);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending.size());
      $display("[bounded_array_list_engine] ERROR");
      $finish;
    end
  end

  // idle cycles before the next item, mostly none or short
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // entered and left at a falling edge; valid stays up for a following item
  task automatic send_item(bal_pkg::op_t o, logic [4:0] p, logic [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      op       <= 3'($urandom_range(0, 7));
      value    <= $urandom();
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    position <= p;
    value    <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // word to store or look for: random, small repeats, extremes or a held word
  function automatic logic [31:0] pick_word(int copy_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < copy_pct && list_len > 0) return list_words[$urandom_range(0, list_len - 1)];
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom();
    if (r < 80) return 32'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      default: return 32'h0;
    endcase
  endfunction

  // mostly legal positions, some at the edge and some anywhere in the field
  function automatic logic [4:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 5'($urandom_range(0, list_len));
    if (r < 90) return 5'($urandom_range(0, 31));
    return 5'(list_len + $urandom_range(0, 1));
  endfunction

  // refusals on an empty list
  task automatic test_empty_list();
    send_item(bal_pkg::OP_POP_BACK, 5'd0, 32'h0);
    send_item(bal_pkg::OP_POP_FRONT, 5'd31, 32'hffff_ffff);
    send_item(bal_pkg::OP_ERASE, 5'd0, 32'h0);
  endtask

  // fill every cell with a mix of pushes and inserts, extremes first
  task automatic test_fill_to_full();
    logic [31:0] seeds [9];
    logic [31:0] v;
    seeds = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1,
              32'h5, 32'h5555_5555, 32'haaaa_aaaa, 32'h5};
    for (int i = 0; i < LIST_DEPTH; i++) begin
      v = (i < 9) ? seeds[i] : $urandom();
      case (i % 3)
        0:       send_item(bal_pkg::OP_PUSH_BACK, 5'($urandom_range(0, 31)), v);
        1:       send_item(bal_pkg::OP_PUSH_FRONT, 5'($urandom_range(0, 31)), v);
        default: send_item(bal_pkg::OP_INSERT, 5'(i / 2), v);
      endcase
    end
  endtask

  // a push and an insert at the end on a full list, and an insert past the end that must report range
  task automatic test_full_list();
    send_item(bal_pkg::OP_PUSH_BACK, 5'd0, 32'h1234_5678);
    send_item(bal_pkg::OP_INSERT, 5'd17, 32'h1);
    send_item(bal_pkg::OP_INSERT, 5'd16, 32'h2);
  endtask

  // first match among duplicates, and a miss
  task automatic test_search();
    send_item(bal_pkg::OP_FIND, 5'd0, 32'h5);
    send_item(bal_pkg::OP_FIND, 5'd9, 32'h8000_0000);
    send_item(bal_pkg::OP_FIND, 5'd0, 32'h1357_9bdf);
  endtask

  // removal from the front, the last slot, and past the end
  task automatic test_removal();
    send_item(bal_pkg::OP_POP_FRONT, 5'd0, 32'h0);
    send_item(bal_pkg::OP_ERASE, 5'(list_len - 1), 32'h0);
    send_item(bal_pkg::OP_ERASE, 5'd20, 32'h0);
  endtask

  task automatic test_clear();
    send_item(bal_pkg::OP_CLEAR, 5'd31, 32'hffff_ffff);
  endtask

  // random mix drifting between filling, draining and steady phases
  task automatic test_random_mix(int n_items);
    int push_pct;
    int r;
    bal_pkg::op_t o;
    push_pct = 43;
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 60;
          1:       push_pct = 20;
          default: push_pct = 43;
        endcase
      end
      quiet = ((n / 40) % 5 == 4);
      r = $urandom_range(0, 99);
      if (r < 2) begin
        o = bal_pkg::OP_CLEAR;
      end else if (r < 14) begin
        o = bal_pkg::OP_FIND;
      end else if (r < 14 + push_pct) begin
        case ($urandom_range(0, 2))
          0:       o = bal_pkg::OP_PUSH_BACK;
          1:       o = bal_pkg::OP_PUSH_FRONT;
          default: o = bal_pkg::OP_INSERT;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       o = bal_pkg::OP_POP_BACK;
          1:       o = bal_pkg::OP_POP_FRONT;
          default: o = bal_pkg::OP_ERASE;
        endcase
      end
      send_item(o, pick_position(), pick_word(o == bal_pkg::OP_FIND ? 60 : 5));
    end
    quiet = 1'b0;
  endtask

  // results held off for a long stretch while items keep arriving
  task automatic test_backpressure();
    quiet = 1'b1;
    hold_reqs++;
    for (int n = 0; n < 40; n++) begin
      case (n % 4)
        0:       send_item(bal_pkg::OP_PUSH_BACK, pick_position(), pick_word(0));
        1:       send_item(bal_pkg::OP_FIND, pick_position(), pick_word(70));
        2:       send_item(bal_pkg::OP_INSERT, pick_position(), pick_word(0));
        default: send_item(bal_pkg::OP_POP_FRONT, pick_position(), pick_word(0));
      endcase
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    op        = bal_pkg::OP_PUSH_BACK;
    position  = '0;
    value     = '0;
    out_stall = 1'b0;
    list_len  = 0;
    quiet     = 1'b0;
    hold_reqs = 0;
    hold_done = 0;
    hold_left = 0;
    stall_left = 0;
    errors    = 0;
    cycle_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_fill_to_full();
    test_full_list();
    test_search();
    test_removal();
    test_clear();
    test_random_mix(470);
    test_backpressure();
    test_random_mix(60);

    // let the last results drain
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results for %0d requests: %0d finds hit, %0d refused",
             checked, accepted, finds_hit, refused);
    $display("list seen full %0d times and empty %0d times, %0d mismatches",
             full_seen, empty_seen, errors);
    if (errors == 0) begin
      $display("[bounded_array_list_engine] OK");
    end else begin
      $display("[bounded_array_list_engine] ERROR");
    end
    $finish;
  end

endmodule
